// ===== rtl/broken_down_time_to_epoch_usec_macros.svh =====
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_usec assertion macros
// shared concurrent assertion forms for the conversion pipeline
// ----------------------------------------------------------------------------
`ifndef BROKEN_DOWN_TIME_TO_EPOCH_USEC_MACROS_SVH
`define BROKEN_DOWN_TIME_TO_EPOCH_USEC_MACROS_SVH

// same-cycle implication, disabled during reset
`define BDT_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define BDT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/bdt_pkg.sv =====
// ----------------------------------------------------------------------------
// bdt_pkg
// types and constants shared by the time conversion pipeline
// ----------------------------------------------------------------------------
package bdt_pkg;

    localparam logic [3:0]         MONTHS       = 4'd12;
    localparam logic [3:0]         MARCH_IDX    = 4'd2;
    localparam logic [5:0]         DIV100_MUL   = 6'd41;
    localparam logic [18:0]        DAYS_PER_YR  = 19'd365;
    localparam logic signed [20:0] DAYS_NEG_YR  = 21'sd365;
    localparam logic signed [20:0] EPOCH_DAY    = 21'sd25508;
    localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;

    // fields that ride along the date and seconds stages
    typedef struct packed {
        logic               op;
        logic               bad;
        logic [19:0]        us;
        logic signed [17:0] off;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic signed [20:0] days;
        logic [4:0]         hr;
        logic [5:0]         mn;
        logic [5:0]         sc;
    } t_days_item;

    typedef struct packed {
        t_side              side;
        logic signed [37:0] secs;
    } t_secs_item;

    // day of the march-based year on which each month starts
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd0:    d = 9'd306;
            4'd1:    d = 9'd337;
            4'd2:    d = 9'd0;
            4'd3:    d = 9'd31;
            4'd4:    d = 9'd61;
            4'd5:    d = 9'd92;
            4'd6:    d = 9'd122;
            4'd7:    d = 9'd153;
            4'd8:    d = 9'd184;
            4'd9:    d = 9'd214;
            4'd10:   d = 9'd245;
            4'd11:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/broken_down_time_to_epoch_usec.sv =====
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_usec
// gregorian broken-down time to microseconds since 1970-01-01
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready carry one transaction of calendar fields,
// operation and utc offset; output channel: o_valid / i_ready carry
// o_epoch_usec and o_status, one result per input transaction, in order.
// throughput is one transaction per cycle while i_ready stays high; the
// eight register stages are the year split, the day count, the hour,
// minute and second multiply-adds, the split microsecond scaling, the
// partial sums and the final add.
// each stage holds its own valid bit, so bubbles close up while the
// receiver stalls and input is still taken until every stage is full.
// a bad month or a time before the epoch gives status 1 and a zero time.
// synchronous reset empties the pipeline; no transaction is in flight after.
// ----------------------------------------------------------------------------
`include "broken_down_time_to_epoch_usec_macros.svh"

module broken_down_time_to_epoch_usec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic [9:0]         i_years_since_1900,
    input  logic [3:0]         i_month_index,
    input  logic [4:0]         i_day_of_month,
    input  logic [4:0]         i_hour_of_day,
    input  logic [5:0]         i_minute_of_hour,
    input  logic [5:0]         i_second_of_minute,
    input  logic [19:0]        i_micro_seconds,
    input  logic signed [17:0] i_utc_offset_seconds,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [55:0] o_epoch_usec,
    output logic               o_status
);

    logic                days_vld;
    logic                days_rdy;
    bdt_pkg::t_days_item days_item;
    logic                secs_vld;
    logic                secs_rdy;
    bdt_pkg::t_secs_item secs_item;

    bdt_date u_date (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_operation          (i_operation),
        .i_years_since_1900   (i_years_since_1900),
        .i_month_index        (i_month_index),
        .i_day_of_month       (i_day_of_month),
        .i_hour_of_day        (i_hour_of_day),
        .i_minute_of_hour     (i_minute_of_hour),
        .i_second_of_minute   (i_second_of_minute),
        .i_micro_seconds      (i_micro_seconds),
        .i_utc_offset_seconds (i_utc_offset_seconds),
        .o_valid              (days_vld),
        .i_ready              (days_rdy),
        .o_item               (days_item)
    );

    bdt_secs u_secs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (days_vld),
        .o_ready (days_rdy),
        .i_item  (days_item),
        .o_valid (secs_vld),
        .i_ready (secs_rdy),
        .o_item  (secs_item)
    );

    bdt_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (secs_vld),
        .o_ready      (secs_rdy),
        .i_item       (secs_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_epoch_usec (o_epoch_usec),
        .o_status     (o_status)
    );

    // an error result always carries a zero time
    `BDT_ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_valid && o_status, o_epoch_usec == 56'sd0)
    // an empty output stage means the whole pipeline can take input
    `BDT_ASSERT_IMPLIES(a_empty_ready, i_clk, i_rst_n, !o_valid, o_ready)
    // an empty output with no input leaves the first stage open next cycle
    `BDT_ASSERT_NEXT(a_drain_ready, i_clk, i_rst_n, !o_valid && !i_valid, o_ready)

endmodule

// ===== rtl/bdt_date.sv =====
// ----------------------------------------------------------------------------
// bdt_date
// two stages: march-based year and century split, then day count since epoch
// ----------------------------------------------------------------------------
module bdt_date (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  logic [9:0]          i_years_since_1900,
    input  logic [3:0]          i_month_index,
    input  logic [4:0]          i_day_of_month,
    input  logic [4:0]          i_hour_of_day,
    input  logic [5:0]          i_minute_of_hour,
    input  logic [5:0]          i_second_of_minute,
    input  logic [19:0]         i_micro_seconds,
    input  logic signed [17:0]  i_utc_offset_seconds,
    output logic                o_valid,
    input  logic                i_ready,
    output bdt_pkg::t_days_item o_item
);

    typedef struct packed {
        bdt_pkg::t_side side;
        logic           neg;
        logic [9:0]     yu;
        logic [3:0]     q100;
        logic [8:0]     mstart;
        logic [4:0]     mday;
        logic [4:0]     hr;
        logic [5:0]     mn;
        logic [5:0]     sc;
    } t_year_item;

    logic                r_a_vld;
    t_year_item          r_a;
    t_year_item          n_a;
    logic                r_b_vld;
    bdt_pkg::t_days_item r_b;
    bdt_pkg::t_days_item n_b;
    logic                adv_a;
    logic                adv_b;
    logic                early;
    logic [15:0]         q_prod;
    logic [18:0]         y365;
    logic [2:0]          leap400;
    logic [19:0]         base_u;
    logic signed [20:0]  days_y;

    assign adv_b   = ~r_b_vld | i_ready;
    assign adv_a   = ~r_a_vld | adv_b;
    assign o_ready = adv_a;
    assign o_valid = r_b_vld;
    assign o_item  = r_b;

    // stage a: shift the year to start in march, divide by 100 by reciprocal
    always_comb begin
        early         = i_month_index < bdt_pkg::MARCH_IDX;
        n_a.side.op   = i_operation;
        n_a.side.bad  = i_month_index >= bdt_pkg::MONTHS;
        n_a.side.us   = i_micro_seconds;
        n_a.side.off  = i_utc_offset_seconds;
        n_a.neg       = early && (i_years_since_1900 == 10'd0);
        n_a.yu        = early ? i_years_since_1900 - 10'd1 : i_years_since_1900;
        q_prod        = {6'b0, n_a.yu} * {10'b0, bdt_pkg::DIV100_MUL};
        n_a.q100      = q_prod[15:12];
        n_a.mstart    = bdt_pkg::month_start(i_month_index);
        n_a.mday      = i_day_of_month;
        n_a.hr        = i_hour_of_day;
        n_a.mn        = i_minute_of_hour;
        n_a.sc        = i_second_of_minute;
    end

    // stage b: days since 1 march 1900, then relative to the epoch
    always_comb begin
        y365     = {9'b0, r_a.yu} * bdt_pkg::DAYS_PER_YR;
        leap400  = 3'(({1'b0, r_a.q100} + 5'd3) >> 2);
        base_u   = {1'b0, y365} + {12'b0, r_a.yu[9:2]} + {17'b0, leap400}
                 - {16'b0, r_a.q100};
        days_y   = r_a.neg ? -bdt_pkg::DAYS_NEG_YR : $signed({1'b0, base_u});
        n_b.side = r_a.side;
        n_b.days = days_y + $signed({12'b0, r_a.mstart}) + $signed({16'b0, r_a.mday})
                 - 21'sd1 - bdt_pkg::EPOCH_DAY;
        n_b.hr   = r_a.hr;
        n_b.mn   = r_a.mn;
        n_b.sc   = r_a.sc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_vld <= i_valid;
            end
            if (adv_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a <= n_a;
        end
        if (adv_b) begin
            r_b <= n_b;
        end
    end

endmodule

// ===== rtl/bdt_secs.sv =====
// ----------------------------------------------------------------------------
// bdt_secs
// three stages folding hour, minute and second into seconds since epoch
// ----------------------------------------------------------------------------
module bdt_secs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bdt_pkg::t_days_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output bdt_pkg::t_secs_item o_item
);

    logic               r_h_vld;
    logic               r_m_vld;
    logic               r_s_vld;
    bdt_pkg::t_side     r_h_side;
    bdt_pkg::t_side     r_m_side;
    bdt_pkg::t_side     r_s_side;
    logic signed [25:0] r_h;
    logic signed [25:0] n_h;
    logic signed [31:0] r_m;
    logic signed [31:0] n_m;
    logic signed [37:0] r_s;
    logic signed [37:0] n_s;
    logic [5:0]         r_h_mn;
    logic [5:0]         r_h_sc;
    logic [5:0]         r_m_sc;
    logic               adv_h;
    logic               adv_m;
    logic               adv_s;

    assign adv_s   = ~r_s_vld | i_ready;
    assign adv_m   = ~r_m_vld | adv_s;
    assign adv_h   = ~r_h_vld | adv_m;
    assign o_ready = adv_h;
    assign o_valid = r_s_vld;
    assign o_item  = '{side: r_s_side, secs: r_s};

    always_comb begin
        n_h = $signed({{5{i_item.days[20]}}, i_item.days}) * 26'sd24
            + $signed({21'b0, i_item.hr});
        n_m = $signed({{6{r_h[25]}}, r_h}) * 32'sd60 + $signed({26'b0, r_h_mn});
        n_s = $signed({{6{r_m[31]}}, r_m}) * 38'sd60 + $signed({32'b0, r_m_sc});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            if (adv_h) begin
                r_h_vld <= i_valid;
            end
            if (adv_m) begin
                r_m_vld <= r_h_vld;
            end
            if (adv_s) begin
                r_s_vld <= r_m_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_h) begin
            r_h      <= n_h;
            r_h_side <= i_item.side;
            r_h_mn   <= i_item.mn;
            r_h_sc   <= i_item.sc;
        end
        if (adv_m) begin
            r_m      <= n_m;
            r_m_side <= r_h_side;
            r_m_sc   <= r_h_sc;
        end
        if (adv_s) begin
            r_s      <= n_s;
            r_s_side <= r_m_side;
        end
    end

endmodule

// ===== rtl/bdt_scale.sv =====
// ----------------------------------------------------------------------------
// bdt_scale
// three stages: split microsecond scaling, partial sums, final add and error
// ----------------------------------------------------------------------------
module bdt_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bdt_pkg::t_secs_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [55:0]  o_epoch_usec,
    output logic                o_status
);

    logic               r_p_vld;
    logic               r_q_vld;
    logic               r_o_vld;
    logic               r_p_err;
    logic [37:0]        r_p_hi;
    logic [37:0]        r_p_lo;
    logic signed [37:0] r_p_off;
    logic [19:0]        r_p_us;
    logic               r_q_err;
    logic [55:0]        r_q_a;
    logic signed [38:0] r_q_b;
    logic signed [55:0] r_o_usec;
    logic               r_o_status;
    logic               n_p_err;
    logic [37:0]        n_p_hi;
    logic [37:0]        n_p_lo;
    logic signed [37:0] n_p_off;
    logic [55:0]        n_q_a;
    logic signed [38:0] n_q_b;
    logic signed [56:0] sum;
    logic               adv_p;
    logic               adv_q;
    logic               adv_o;

    assign adv_o        = ~r_o_vld | i_ready;
    assign adv_q        = ~r_q_vld | adv_o;
    assign adv_p        = ~r_p_vld | adv_q;
    assign o_ready      = adv_p;
    assign o_valid      = r_o_vld;
    assign o_epoch_usec = r_o_usec;
    assign o_status     = r_o_status;

    always_comb begin
        n_p_err = i_item.side.bad | i_item.secs[37];
        n_p_hi  = {20'b0, i_item.secs[35:18]} * {18'b0, bdt_pkg::USEC_PER_SEC};
        n_p_lo  = {20'b0, i_item.secs[17:0]} * {18'b0, bdt_pkg::USEC_PER_SEC};
        n_p_off = i_item.side.op
                ? $signed({{20{i_item.side.off[17]}}, i_item.side.off})
                  * $signed({18'b0, bdt_pkg::USEC_PER_SEC})
                : 38'sd0;
        n_q_a   = {r_p_hi[37:0], 18'b0} + {18'b0, r_p_lo};
        n_q_b   = $signed({19'b0, r_p_us}) - $signed({r_p_off[37], r_p_off});
        sum     = $signed({1'b0, r_q_a}) + $signed({{18{r_q_b[38]}}, r_q_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_q_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (adv_p) begin
                r_p_vld <= i_valid;
            end
            if (adv_q) begin
                r_q_vld <= r_p_vld;
            end
            if (adv_o) begin
                r_o_vld <= r_q_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_p) begin
            r_p_err <= n_p_err;
            r_p_hi  <= n_p_hi;
            r_p_lo  <= n_p_lo;
            r_p_off <= n_p_off;
            r_p_us  <= i_item.side.us;
        end
        if (adv_q) begin
            r_q_err <= r_p_err;
            r_q_a   <= n_q_a;
            r_q_b   <= n_q_b;
        end
        if (adv_o) begin
            r_o_usec   <= r_q_err ? 56'sd0 : sum[55:0];
            r_o_status <= r_q_err;
        end
    end

endmodule

// ===== tb/broken_down_time_to_epoch_usec_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_usec_tb
// self-checking bench for the calendar time to epoch microseconds pipeline:
// a small predictor computes the expected time and status of every accepted
// transaction, and a scoreboard compares each returned result in order.
// directed corner cases come first, then random calendar times under four
// handshake phases (no idling, sender idle, receiver stalling, both), with
// pauses that let the pipeline drain completely.
// ----------------------------------------------------------------------------

localparam longint USEC_PER_SECOND = 1000000;
localparam longint DAYS_PER_YEAR   = 365;

typedef struct {
    logic               op;
    logic [9:0]         years;
    logic [3:0]         month;
    logic [4:0]         mday;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [19:0]        usec;
    logic signed [17:0] offset;
} t_time_req;

typedef struct {
    logic signed [55:0] epoch_usec;
    logic               status;
} t_epoch_result;

class epoch_tracker;
    t_epoch_result expected_times[$];
    int            failures;

    function new();
        failures = 0;
    endfunction

    function automatic t_epoch_result civil_to_epoch(t_time_req r);
        longint        march_day[12] = '{306, 337, 0, 31, 61, 92, 122, 153, 184, 214, 245, 275};
        longint        yr;
        longint        days;
        longint        secs;
        longint        total;
        t_epoch_result res;
        res.epoch_usec = '0;
        res.status     = 1'b1;
        if (r.month >= bdt_pkg::MONTHS) begin
            return res;
        end
        yr = longint'(r.years);
        if (r.month < bdt_pkg::MARCH_IDX) begin
            yr = yr - 1;
        end
        days = yr * DAYS_PER_YEAR + yr / 4 - yr / 100 + (yr / 100 + 3) / 4;
        days = days + march_day[r.month] + longint'(r.mday) - 1;
        days = days - longint'(bdt_pkg::EPOCH_DAY);
        secs = ((days * 24 + longint'(r.hour)) * 60 + longint'(r.minute)) * 60
               + longint'(r.second);
        if (secs < 0) begin
            return res;
        end
        total = secs * USEC_PER_SECOND + longint'(r.usec);
        if (r.op) begin
            total = total - longint'(r.offset) * USEC_PER_SECOND;
        end
        res.epoch_usec = total[55:0];
        res.status     = 1'b0;
        return res;
    endfunction

    function void note_request(t_time_req r);
        expected_times.push_back(civil_to_epoch(r));
    endfunction

    function void check_result(logic signed [55:0] epoch_usec, logic status);
        t_epoch_result want;
        if (expected_times.size() == 0) begin
            $error("result with no transaction outstanding: epoch_usec %0d status %0d",
                   epoch_usec, status);
            failures++;
            return;
        end
        want = expected_times.pop_front();
        if (epoch_usec !== want.epoch_usec) begin
            $error("epoch_usec mismatch: expected %0d actual %0d", want.epoch_usec, epoch_usec);
            failures++;
        end
        if (status !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, status);
            failures++;
        end
    endfunction

    function int outstanding();
        return expected_times.size();
    endfunction
endclass

module broken_down_time_to_epoch_usec_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic [9:0]         i_years_since_1900;
    logic [3:0]         i_month_index;
    logic [4:0]         i_day_of_month;
    logic [4:0]         i_hour_of_day;
    logic [5:0]         i_minute_of_hour;
    logic [5:0]         i_second_of_minute;
    logic [19:0]        i_micro_seconds;
    logic signed [17:0] i_utc_offset_seconds;
    logic               o_valid;
    logic               i_ready;
    logic signed [55:0] o_epoch_usec;
    logic               o_status;

    epoch_tracker tracker;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles;

    broken_down_time_to_epoch_usec dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_operation          (i_operation),
        .i_years_since_1900   (i_years_since_1900),
        .i_month_index        (i_month_index),
        .i_day_of_month       (i_day_of_month),
        .i_hour_of_day        (i_hour_of_day),
        .i_minute_of_hour     (i_minute_of_hour),
        .i_second_of_minute   (i_second_of_minute),
        .i_micro_seconds      (i_micro_seconds),
        .i_utc_offset_seconds (i_utc_offset_seconds),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_epoch_usec         (o_epoch_usec),
        .o_status             (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check, stall at random, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                tracker.check_result(o_epoch_usec, o_status);
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles <= 0;
            end else if (i_valid || tracker.outstanding() > 0) begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_time_req make_req(logic op, int yr, int mon, int mday, int hr,
                                           int mn, int sc, int us, int off);
        t_time_req r;
        r.op     = op;
        r.years  = yr[9:0];
        r.month  = mon[3:0];
        r.mday   = mday[4:0];
        r.hour   = hr[4:0];
        r.minute = mn[5:0];
        r.second = sc[5:0];
        r.usec   = us[19:0];
        r.offset = off[17:0];
        return r;
    endfunction

    function automatic t_time_req random_req();
        t_time_req r;
        int        off;
        off = int'($urandom_range(172800)) - 86400;
        r = make_req($urandom_range(1), 0, 0, 0, 0, 0, 0, $urandom_range(999999), off);
        if ($urandom_range(99) < 80) begin
            r.years = 10'($urandom_range(1023, 70));
        end else begin
            r.years = 10'($urandom_range(1023));
        end
        if ($urandom_range(99) < 75) begin
            r.month  = 4'($urandom_range(11));
            r.mday   = 5'($urandom_range(31, 1));
            r.hour   = 5'($urandom_range(23));
            r.minute = 6'($urandom_range(59));
            r.second = 6'($urandom_range(60));
        end else begin
            r.month  = 4'($urandom_range(15));
            r.mday   = 5'($urandom_range(31));
            r.hour   = 5'($urandom_range(31));
            r.minute = 6'($urandom_range(63));
            r.second = 6'($urandom_range(63));
        end
        return r;
    endfunction

    task automatic send_request(input t_time_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_operation          <= r.op;
        i_years_since_1900   <= r.years;
        i_month_index        <= r.month;
        i_day_of_month       <= r.mday;
        i_hour_of_day        <= r.hour;
        i_minute_of_hour     <= r.minute;
        i_second_of_minute   <= r.second;
        i_micro_seconds      <= r.usec;
        i_utc_offset_seconds <= r.offset;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_request(r);
    endtask

    // hold off input until every outstanding transaction has returned
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() > 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(random_req());
            if (n == count / 2) begin
                drain_pipeline();
            end
        end
        drain_pipeline();
    endtask

    initial begin
        tracker              = new();
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        quiet_cycles         = 0;
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_ready              = 1'b0;
        i_operation          = 1'b0;
        i_years_since_1900   = '0;
        i_month_index        = '0;
        i_day_of_month       = '0;
        i_hour_of_day        = '0;
        i_minute_of_hour     = '0;
        i_second_of_minute   = '0;
        i_micro_seconds      = '0;
        i_utc_offset_seconds = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_request(make_req(0, 70, 0, 1, 0, 0, 0, 0, 0));
        send_request(make_req(1, 70, 0, 1, 0, 0, 0, 0, 86400));
        send_request(make_req(1, 70, 0, 1, 0, 0, 0, 0, -86400));
        send_request(make_req(0, 69, 11, 31, 23, 59, 59, 999999, 0));
        send_request(make_req(0, 69, 11, 31, 24, 0, 0, 0, 0));
        send_request(make_req(0, 0, 0, 1, 0, 0, 0, 0, 0));
        send_request(make_req(1, 0, 1, 31, 31, 63, 63, 999999, 86400));
        send_request(make_req(0, 0, 2, 1, 0, 0, 0, 0, 0));
        send_request(make_req(0, 100, 12, 1, 0, 0, 0, 0, 0));
        send_request(make_req(1, 100, 15, 31, 31, 63, 63, 999999, -86400));
        send_request(make_req(0, 100, 1, 29, 12, 0, 0, 0, 0));
        send_request(make_req(0, 200, 2, 1, 0, 0, 0, 0, 0));
        send_request(make_req(0, 200, 1, 29, 0, 0, 0, 0, 0));
        send_request(make_req(0, 1023, 11, 31, 31, 63, 63, 999999, 0));
        send_request(make_req(1, 1023, 11, 31, 31, 63, 63, 999999, -86400));
        send_request(make_req(1, 1023, 0, 0, 0, 0, 0, 0, 86400));
        send_request(make_req(0, 70, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(0, 70, 0, 0, 31, 63, 63, 0, 0));
        send_request(make_req(1, 124, 5, 15, 8, 30, 60, 500000, -131072));
        send_request(make_req(1, 124, 5, 15, 8, 30, 60, 500000, 131071));
        send_request(make_req(0, 70, 2, 1, 0, 0, 0, 0, 0));
        drain_pipeline();

        run_random(230);
        send_idle_pct = 57;
        run_random(240);
        send_idle_pct  = 0;
        recv_stall_pct <= 57;
        run_random(240);
        send_idle_pct  = 33;
        recv_stall_pct <= 33;
        run_random(240);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.outstanding() > 0) begin
            $error("%0d transactions never returned", tracker.outstanding());
            tracker.failures++;
        end
        if (tracker.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
